FILE: hdl/fbfl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbfl_pkg
// Shared types, codes and constants of the fixed block free list allocator.
// ----------------------------------------------------------------------------
package fbfl_pkg;

    // defaults for the top level parameters
    localparam int MAX_BLOCKS_DEF = 1024;
    localparam int WORD_BYTES_DEF = 8;

    // fixed field widths
    localparam int POOL_W   = 32;
    localparam int REQ_W    = 16;
    localparam int STRIDE_W = 17;
    localparam int OFF_W    = 26;
    localparam int DIV_W    = POOL_W;

    localparam int MGMT_HDR_BYTES = 16;
    localparam int BLK_HDR_BYTES  = 8;

    localparam logic [POOL_W-1:0] POOL_BYTES_RST = 32'd8208;
    localparam logic [REQ_W-1:0]  REQ_BYTES_RST  = 16'd8;

    // configuration register indexes
    localparam logic CFG_POOL_BYTES = 1'b0;
    localparam logic CFG_REQ_BYTES  = 1'b1;

    typedef enum logic [1:0] {
        OP_INIT  = 2'd0,
        OP_ALLOC = 2'd1,
        OP_FREE  = 2'd2,
        OP_QUERY = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_BAD_INDEX = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_STRIDE,
        S_CNT_GO,
        S_COUNT,
        S_LINK,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic                start;
        logic [DIV_W-1:0]    dividend;
        logic [STRIDE_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                done;
        logic [DIV_W-1:0]    quot;
    } t_div_rsp;

endpackage

FILE: hdl/fbfl_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbfl_div
// Restoring divider, one quotient bit per cycle, used for the block count
// of an init.
// ----------------------------------------------------------------------------
module fbfl_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fbfl_pkg::t_div_req i_req,
    output fbfl_pkg::t_div_rsp o_rsp
);

    localparam int DW  = fbfl_pkg::DIV_W;
    localparam int SW  = fbfl_pkg::STRIDE_W;
    localparam int CW  = $clog2(DW);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [SW-1:0] r_rem;
    logic [DW-1:0] r_quo;
    logic [SW-1:0] r_dvs;

    logic [SW:0]   trial;
    logic [SW:0]   diff;
    logic          ge;
    logic [SW-1:0] n_rem;
    logic [DW-1:0] n_quo;

    always_comb begin
        trial = {r_rem, r_quo[DW-1]};
        diff  = trial - {1'b0, r_dvs};
        ge    = (trial >= {1'b0, r_dvs});
        n_rem = ge ? diff[SW-1:0] : trial[SW-1:0];
        n_quo = {r_quo[DW-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == CW'(DW - 1))) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_cnt <= '0;
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CW'(1);
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;

endmodule

FILE: hdl/fbfl_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbfl_ctrl
// Sequencer of the allocator: holds the link memory, the list head and the
// counters, runs init sweeps and the read-modify-write of alloc and free.
// ----------------------------------------------------------------------------
module fbfl_ctrl #(
    parameter int MAX_BLOCKS = fbfl_pkg::MAX_BLOCKS_DEF,
    parameter int WORD_BYTES = fbfl_pkg::WORD_BYTES_DEF,
    localparam int IDX_W     = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1,
    localparam int CNT_W     = $clog2(MAX_BLOCKS + 1)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    output logic                            o_busy,
    input  logic [1:0]                      i_operation,
    input  logic [IDX_W-1:0]                i_block_index,
    input  logic [fbfl_pkg::POOL_W-1:0]     i_pool_bytes,
    input  logic [fbfl_pkg::REQ_W-1:0]      i_req_bytes,
    output fbfl_pkg::t_div_req              o_div_req,
    input  fbfl_pkg::t_div_rsp              i_div_rsp,
    output logic                            o_done,
    output logic [IDX_W-1:0]                o_alloc_index,
    output logic [fbfl_pkg::OFF_W-1:0]      o_alloc_offset,
    output logic [CNT_W-1:0]                o_free_count,
    output logic [1:0]                      o_status
);

    localparam int SW     = fbfl_pkg::STRIDE_W;
    localparam int OW     = fbfl_pkg::OFF_W;
    localparam int PW     = fbfl_pkg::POOL_W;
    localparam int PROD_W = IDX_W + SW;
    localparam int RSH    = 22;
    localparam int RPW    = RSH + SW;
    // reciprocal of the word size, exact for every 17-bit size
    localparam logic [RPW-1:0] RECIP = RPW'(((1 << RSH) + WORD_BYTES - 1) / WORD_BYTES);

    fbfl_pkg::t_state r_state, n_state;
    fbfl_pkg::t_op    r_op;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] r_head, n_head;
    logic [CNT_W-1:0] r_total, n_total;
    logic [CNT_W-1:0] r_counter, n_counter;
    logic [SW-1:0]    r_stride, n_stride;
    logic [SW-1:0]    r_raw;
    logic [CNT_W-1:0] r_fill, n_fill;
    logic [PROD_W-1:0] r_prod;

    logic                 r_done, n_done;
    logic [IDX_W-1:0]     r_aidx, n_aidx;
    logic [OW-1:0]        r_aoff, n_aoff;
    logic [CNT_W-1:0]     r_fcnt, n_fcnt;
    fbfl_pkg::t_status    r_status, n_status;

    // link memory with a registered read port
    logic [IDX_W-1:0] mem [MAX_BLOCKS];
    logic [IDX_W-1:0] r_rdata;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [IDX_W-1:0] mem_wdata;
    logic             mem_re;

    logic                 accept;
    logic [SW-1:0]        raw_now;
    logic [PROD_W+OW-1:0] prod_ext;
    logic [CNT_W-1:0]     fill_inc;
    logic [SW-1:0]        raw_up;
    logic [SW-1:0]        words;
    logic [SW-1:0]        stride_rnd;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rdata <= mem[r_head];
        end
    end

    assign accept   = i_start && (r_state == fbfl_pkg::S_IDLE);
    assign raw_now  = SW'(i_req_bytes) + SW'(fbfl_pkg::BLK_HDR_BYTES);
    assign prod_ext = {{OW{1'b0}}, r_prod};
    assign fill_inc = r_fill + CNT_W'(1);
    assign mem_re   = accept && (fbfl_pkg::t_op'(i_operation) == fbfl_pkg::OP_ALLOC);

    // whole words needed for the block, then back to bytes
    assign raw_up     = r_raw + SW'(WORD_BYTES - 1);
    assign words      = SW'((RPW'(raw_up) * RECIP) >> RSH);
    assign stride_rnd = words * SW'(WORD_BYTES);

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_total   = r_total;
        n_counter = r_counter;
        n_stride  = r_stride;
        n_fill    = r_fill;
        n_done    = 1'b0;
        n_aidx    = '0;
        n_aoff    = '0;
        n_fcnt    = r_counter;
        n_status  = fbfl_pkg::ST_OK;
        mem_we    = 1'b0;
        mem_waddr = r_idx;
        mem_wdata = r_head;
        o_div_req.start    = 1'b0;
        o_div_req.dividend = '0;
        o_div_req.divisor  = '0;

        case (r_state)
            fbfl_pkg::S_IDLE: begin
                if (accept) begin
                    if (fbfl_pkg::t_op'(i_operation) == fbfl_pkg::OP_INIT) begin
                        n_state = fbfl_pkg::S_STRIDE;
                    end else begin
                        n_state = fbfl_pkg::S_EXEC;
                    end
                end
            end
            fbfl_pkg::S_STRIDE: begin
                // round up to whole words, an aligned size keeps its size
                n_stride = stride_rnd;
                n_state  = fbfl_pkg::S_CNT_GO;
            end
            fbfl_pkg::S_CNT_GO: begin
                n_fill = '0;
                if (i_pool_bytes < PW'(fbfl_pkg::MGMT_HDR_BYTES)) begin
                    n_total = '0;
                    n_state = fbfl_pkg::S_LINK;
                end else begin
                    o_div_req.start    = 1'b1;
                    o_div_req.dividend = i_pool_bytes - PW'(fbfl_pkg::MGMT_HDR_BYTES);
                    o_div_req.divisor  = r_stride;
                    n_state = fbfl_pkg::S_COUNT;
                end
            end
            fbfl_pkg::S_COUNT: begin
                if (i_div_rsp.done) begin
                    if (i_div_rsp.quot > fbfl_pkg::DIV_W'(MAX_BLOCKS)) begin
                        n_total = CNT_W'(MAX_BLOCKS);
                    end else begin
                        n_total = CNT_W'(i_div_rsp.quot);
                    end
                    n_state = fbfl_pkg::S_LINK;
                end
            end
            fbfl_pkg::S_LINK: begin
                if (r_fill == r_total) begin
                    n_head    = '0;
                    n_counter = r_total;
                    n_done    = 1'b1;
                    n_fcnt    = r_total;
                    n_state   = fbfl_pkg::S_IDLE;
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = r_fill[IDX_W-1:0];
                    mem_wdata = (fill_inc < r_total) ? fill_inc[IDX_W-1:0] : '0;
                    n_fill    = fill_inc;
                end
            end
            fbfl_pkg::S_EXEC: begin
                n_done  = 1'b1;
                n_state = fbfl_pkg::S_IDLE;
                case (r_op)
                    fbfl_pkg::OP_ALLOC: begin
                        if (r_counter == '0) begin
                            n_status = fbfl_pkg::ST_EMPTY;
                        end else begin
                            n_aidx    = r_head;
                            n_aoff    = prod_ext[OW-1:0]
                                        + OW'(fbfl_pkg::MGMT_HDR_BYTES + fbfl_pkg::BLK_HDR_BYTES);
                            n_head    = r_rdata;
                            n_counter = r_counter - CNT_W'(1);
                        end
                    end
                    fbfl_pkg::OP_FREE: begin
                        if (CNT_W'(r_idx) >= r_total) begin
                            n_status = fbfl_pkg::ST_BAD_INDEX;
                        end else begin
                            mem_we = 1'b1;
                            n_head = r_idx;
                            if (r_counter < r_total) begin
                                n_counter = r_counter + CNT_W'(1);
                            end
                        end
                    end
                    default: begin
                    end
                endcase
                n_fcnt = n_counter;
            end
            default: begin
                n_state = fbfl_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= fbfl_pkg::S_IDLE;
            r_head    <= '0;
            r_total   <= '0;
            r_counter <= '0;
            r_stride  <= '0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_total   <= n_total;
            r_counter <= n_counter;
            r_stride  <= n_stride;
            r_done    <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fill   <= n_fill;
        r_aidx   <= n_aidx;
        r_aoff   <= n_aoff;
        r_fcnt   <= n_fcnt;
        r_status <= n_status;
        if (accept) begin
            r_op   <= fbfl_pkg::t_op'(i_operation);
            r_idx  <= i_block_index;
            r_raw  <= raw_now;
            // product ready for the offset add in the next cycle
            r_prod <= PROD_W'(r_head) * PROD_W'(r_stride);
        end
    end

    assign o_busy         = (r_state != fbfl_pkg::S_IDLE);
    assign o_done         = r_done;
    assign o_alloc_index  = r_aidx;
    assign o_alloc_offset = r_aoff;
    assign o_free_count   = r_fcnt;
    assign o_status       = r_status;

endmodule

FILE: hdl/fixed_block_free_list_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator_unit
// Fixed-size block allocator with a LIFO free list kept in a link memory.
// ----------------------------------------------------------------------------
// Usage:
//   A command is taken at a clock edge where start is high and busy is low.
//   i_operation selects init, alloc, free or query; i_block_index is the
//   block to free. Every command returns one word on the result ports,
//   marked by o_done for a single cycle; the receiver cannot stall it.
//   Alloc, free and query: the command goes to the execute state and o_done
//   is registered from it; a new command can be taken while o_done is high.
//   Alloc reads the link memory as the command is taken (head entry and
//   index times stride) and updates in the execute state.
//   Init: stride rounding, a divider pass for the block count and one link
//   memory write per block; a pool below the management header skips the
//   divider.
//   The configuration port (i_cfg_valid / o_cfg_ready, index and data) is
//   always ready. The user must write it only while the unit is idle; the
//   unit does not enforce it. After reset the pool holds no blocks until
//   an init; the registers hold a pool of 8208 bytes and an 8-byte payload.
// ----------------------------------------------------------------------------
module fixed_block_free_list_allocator_unit #(
    parameter int MAX_BLOCKS = fbfl_pkg::MAX_BLOCKS_DEF,
    parameter int WORD_BYTES = fbfl_pkg::WORD_BYTES_DEF,
    localparam int IDX_W     = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1,
    localparam int CNT_W     = $clog2(MAX_BLOCKS + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_operation,
    input  logic [IDX_W-1:0]              i_block_index,
    output logic                          o_done,
    output logic [IDX_W-1:0]              o_alloc_index,
    output logic [fbfl_pkg::OFF_W-1:0]    o_alloc_offset,
    output logic [CNT_W-1:0]              o_free_count,
    output logic [1:0]                    o_status,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_index,
    input  logic [fbfl_pkg::POOL_W-1:0]   i_cfg_data
);

    logic [fbfl_pkg::POOL_W-1:0] r_pool_bytes;
    logic [fbfl_pkg::REQ_W-1:0]  r_req_bytes;

    fbfl_pkg::t_div_req div_req;
    fbfl_pkg::t_div_rsp div_rsp;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_bytes <= fbfl_pkg::POOL_BYTES_RST;
            r_req_bytes  <= fbfl_pkg::REQ_BYTES_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                fbfl_pkg::CFG_POOL_BYTES: r_pool_bytes <= i_cfg_data;
                fbfl_pkg::CFG_REQ_BYTES:  r_req_bytes  <= i_cfg_data[fbfl_pkg::REQ_W-1:0];
                default: begin
                end
            endcase
        end
    end

    fbfl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    fbfl_ctrl #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .WORD_BYTES (WORD_BYTES)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .o_busy         (busy),
        .i_operation    (i_operation),
        .i_block_index  (i_block_index),
        .i_pool_bytes   (r_pool_bytes),
        .i_req_bytes    (r_req_bytes),
        .o_div_req      (div_req),
        .i_div_rsp      (div_rsp),
        .o_done         (o_done),
        .o_alloc_index  (o_alloc_index),
        .o_alloc_offset (o_alloc_offset),
        .o_free_count   (o_free_count),
        .o_status       (o_status)
    );

endmodule

FILE: hdl/fbfl_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbfl_chk
// Port-level checks of the allocator's command and result timing and of its result fields.
// ----------------------------------------------------------------------------
module fbfl_chk #(
    parameter int MAX_BLOCKS = fbfl_pkg::MAX_BLOCKS_DEF,
    localparam int IDX_W     = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1,
    localparam int CNT_W     = $clog2(MAX_BLOCKS + 1)
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       start,
    input logic                       busy,
    input logic [1:0]                 i_operation,
    input logic                       o_done,
    input logic [IDX_W-1:0]           o_alloc_index,
    input logic [fbfl_pkg::OFF_W-1:0] o_alloc_offset,
    input logic [CNT_W-1:0]           o_free_count,
    input logic [1:0]                 o_status
);

    // result word only shows once the unit is free again
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    a_short_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_operation != fbfl_pkg::OP_INIT)) |-> ##2 o_done)
        else $error("alloc/free/query result not two cycles after command");

    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> !o_done)
        else $error("result strobe right after command");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status != fbfl_pkg::ST_OK)) |->
            ((o_alloc_index == '0) && (o_alloc_offset == '0)))
        else $error("failed command reports nonzero index or offset");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == fbfl_pkg::ST_EMPTY)) |-> (o_free_count == '0))
        else $error("empty status with nonzero free count");

endmodule

bind fixed_block_free_list_allocator_unit fbfl_chk #(
    .MAX_BLOCKS (MAX_BLOCKS)
) u_fbfl_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_operation    (i_operation),
    .o_done         (o_done),
    .o_alloc_index  (o_alloc_index),
    .o_alloc_offset (o_alloc_offset),
    .o_free_count   (o_free_count),
    .o_status       (o_status)
);

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the fixed block free list allocator. Commands are
// driven on the start/busy port and a local allocator model predicts every
// result word, which is checked field by field as o_done strobes it. Directed
// tests cover the reset state, stride rounding, small pools, saturation,
// empty lists, bad indexes and double frees. Random phases then run mixed
// traffic under several pool and payload settings.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int N_BLK       = fbfl_pkg::MAX_BLOCKS_DEF;
    localparam int IDX_W       = 10;
    localparam int CNT_W       = 11;
    localparam int OFF_W       = fbfl_pkg::OFF_W;
    localparam int POOL_W      = fbfl_pkg::POOL_W;
    localparam int STALL_LIMIT = 6000;
    localparam int N_PHASES    = 10;
    localparam int PHASE_ITEMS = 195;

    typedef struct packed {
        logic [IDX_W-1:0]  index;
        logic [OFF_W-1:0]  offset;
        logic [CNT_W-1:0]  count;
        fbfl_pkg::t_status status;
    } t_result;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              start         = 1'b0;
    logic [1:0]        i_operation   = fbfl_pkg::OP_QUERY;
    logic [IDX_W-1:0]  i_block_index = '0;
    logic              i_cfg_valid   = 1'b0;
    logic              i_cfg_index   = fbfl_pkg::CFG_POOL_BYTES;
    logic [POOL_W-1:0] i_cfg_data    = '0;

    logic              busy;
    logic              o_done;
    logic [IDX_W-1:0]  o_alloc_index;
    logic [OFF_W-1:0]  o_alloc_offset;
    logic [CNT_W-1:0]  o_free_count;
    logic [1:0]        o_status;
    logic              o_cfg_ready;

    // allocator model state
    logic [10:0]       link_mem [N_BLK];
    logic [10:0]       head_ptr;
    logic [10:0]       total_blocks;
    logic [10:0]       free_cnt;
    logic [16:0]       stride_bytes;
    logic [31:0]       cfg_pool;
    logic [15:0]       cfg_req;

    t_result           pending_results[$];
    int                errors      = 0;
    int                idle_cycles = 0;
    logic              no_gaps     = 1'b0;

    fixed_block_free_list_allocator_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_operation    (i_operation),
        .i_block_index  (i_block_index),
        .o_done         (o_done),
        .o_alloc_index  (o_alloc_index),
        .o_alloc_offset (o_alloc_offset),
        .o_free_count   (o_free_count),
        .o_status       (o_status),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic logic [16:0] stride_for(logic [15:0] req);
        logic [31:0] raw;
        raw = 32'(req) + fbfl_pkg::BLK_HDR_BYTES + fbfl_pkg::WORD_BYTES_DEF - 1;
        return 17'((raw / fbfl_pkg::WORD_BYTES_DEF) * fbfl_pkg::WORD_BYTES_DEF);
    endfunction

    // advances the model by one command and returns the word it should give
    function automatic t_result alloc_model_step(fbfl_pkg::t_op op, logic [IDX_W-1:0] idx);
        t_result     r;
        logic [31:0] cnt;
        logic [63:0] off;
        r        = '0;
        r.status = fbfl_pkg::ST_OK;
        case (op)
            fbfl_pkg::OP_INIT: begin
                stride_bytes = stride_for(cfg_req);
                cnt = 32'd0;
                if (cfg_pool >= fbfl_pkg::MGMT_HDR_BYTES)
                    cnt = (cfg_pool - fbfl_pkg::MGMT_HDR_BYTES) / stride_bytes;
                if (cnt > N_BLK)
                    cnt = N_BLK;
                for (int i = 0; i < cnt; i++)
                    link_mem[i] = (i + 1 < cnt) ? 11'(i + 1) : 11'd0;
                total_blocks = cnt[10:0];
                head_ptr     = '0;
                free_cnt     = cnt[10:0];
            end
            fbfl_pkg::OP_ALLOC: begin
                if (free_cnt == 0 || head_ptr >= N_BLK) begin
                    r.status = fbfl_pkg::ST_EMPTY;
                end else begin
                    r.index  = head_ptr[IDX_W-1:0];
                    off      = 64'(fbfl_pkg::MGMT_HDR_BYTES)
                               + 64'(head_ptr) * 64'(stride_bytes)
                               + 64'(fbfl_pkg::BLK_HDR_BYTES);
                    r.offset = off[OFF_W-1:0];
                    head_ptr = link_mem[head_ptr[IDX_W-1:0]];
                    free_cnt = free_cnt - 1'b1;
                end
            end
            fbfl_pkg::OP_FREE: begin
                if ({1'b0, idx} >= total_blocks) begin
                    r.status = fbfl_pkg::ST_BAD_INDEX;
                end else begin
                    link_mem[idx] = head_ptr;
                    head_ptr      = {1'b0, idx};
                    // double frees are not caught, the count just saturates
                    if (free_cnt < total_blocks)
                        free_cnt = free_cnt + 1'b1;
                end
            end
            default: ;
        endcase
        r.count = free_cnt;
        return r;
    endfunction

    task automatic send_cmd(fbfl_pkg::t_op op, logic [IDX_W-1:0] idx);
        start         <= 1'b1;
        i_operation   <= op;
        i_block_index <= idx;
        do @(posedge i_clk); while (busy);
        pending_results.push_back(alloc_model_step(op, idx));
        if (!no_gaps && $urandom_range(0, 99) < 7) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0 || busy);
    endtask

    // writes both registers; only called with the unit idle
    task automatic configure(logic [31:0] pool, logic [31:0] req_word);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= fbfl_pkg::CFG_POOL_BYTES;
        i_cfg_data  <= pool;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_pool = pool;
        i_cfg_index <= fbfl_pkg::CFG_REQ_BYTES;
        i_cfg_data  <= req_word;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_req = req_word[15:0];
        i_cfg_valid <= 1'b0;
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected word: index %0d offset %0d count %0d status %0d",
                         $time, o_alloc_index, o_alloc_offset, o_free_count, o_status);
            end else begin
                want = pending_results.pop_front();
                check_field("alloc_index", 32'(want.index), 32'(o_alloc_index));
                check_field("alloc_offset", 32'(want.offset), 32'(o_alloc_offset));
                check_field("free_count", 32'(want.count), 32'(o_free_count));
                check_field("status", 32'(want.status), 32'(o_status));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic test_before_init();
        send_cmd(fbfl_pkg::OP_ALLOC, '0);
        send_cmd(fbfl_pkg::OP_FREE, '0);
        send_cmd(fbfl_pkg::OP_FREE, 10'h3FF);
        send_cmd(fbfl_pkg::OP_QUERY, '0);
    endtask

    task automatic test_default_pool();
        send_cmd(fbfl_pkg::OP_INIT, '0);
        send_cmd(fbfl_pkg::OP_ALLOC, '0);
        send_cmd(fbfl_pkg::OP_FREE, 10'd512);
        send_cmd(fbfl_pkg::OP_FREE, '0);
        send_cmd(fbfl_pkg::OP_QUERY, 10'h2AA);
    endtask

    task automatic test_stride_and_size();
        // aligned payload keeps its size: stride 24, three blocks
        wait_idle();
        configure(32'd16 + 32'd24 * 3, 32'd16);
        send_cmd(fbfl_pkg::OP_INIT, '0);
        send_cmd(fbfl_pkg::OP_ALLOC, '0);
        send_cmd(fbfl_pkg::OP_ALLOC, '0);
        // zero payload, stride is the header alone
        wait_idle();
        configure(32'd16 + 32'd8 * 2, 32'd0);
        send_cmd(fbfl_pkg::OP_INIT, '0);
        send_cmd(fbfl_pkg::OP_ALLOC, '0);
        // one byte short of a single block
        wait_idle();
        configure(32'd16 + 32'd16 - 1, 32'd1);
        send_cmd(fbfl_pkg::OP_INIT, '0);
        send_cmd(fbfl_pkg::OP_ALLOC, '0);
        // pool smaller than the management header
        wait_idle();
        configure(32'd15, 32'd8);
        send_cmd(fbfl_pkg::OP_INIT, '0);
        // largest pool and payload: count saturates, largest offset
        wait_idle();
        configure(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_cmd(fbfl_pkg::OP_INIT, '0);
        send_cmd(fbfl_pkg::OP_FREE, 10'h3FF);
        send_cmd(fbfl_pkg::OP_ALLOC, '0);
        send_cmd(fbfl_pkg::OP_ALLOC, '0);
    endtask

    task automatic test_double_free();
        wait_idle();
        configure(32'd16 + 32'd16 * 2, 32'd8);
        send_cmd(fbfl_pkg::OP_INIT, '0);
        send_cmd(fbfl_pkg::OP_FREE, '0);
        send_cmd(fbfl_pkg::OP_ALLOC, '0);
        send_cmd(fbfl_pkg::OP_ALLOC, '0);
        send_cmd(fbfl_pkg::OP_ALLOC, '0);
    endtask

    task automatic test_random_traffic();
        logic [15:0] req;
        logic [16:0] s;
        logic [31:0] pool;
        int          k;
        int          pick;
        for (int p = 0; p < N_PHASES; p++) begin
            if (p == 0)
                req = 16'd0;
            else if (p == 1)
                req = 16'hFFFF;
            else if ($urandom_range(0, 1))
                req = 16'($urandom_range(1, 64));
            else
                req = 16'($urandom_range(1, 65535));
            s = stride_for(req);
            k = $urandom_range(0, 40);
            if (p == 2)
                pool = 32'd0;
            else if (p == 3)
                pool = 32'hFFFF_FFFF;
            else
                pool = 32'(fbfl_pkg::MGMT_HDR_BYTES) + 32'(k) * 32'(s)
                       + $urandom_range(0, 32'(s) - 1);
            wait_idle();
            // upper data bits are junk for the payload register
            configure(pool, {16'($urandom), req});
            no_gaps = (p == 4);
            send_cmd(fbfl_pkg::OP_INIT, 10'($urandom));
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 40)
                    send_cmd(fbfl_pkg::OP_ALLOC, 10'($urandom));
                else if (pick < 75 && total_blocks != 0)
                    send_cmd(fbfl_pkg::OP_FREE,
                             10'($urandom_range(0, 32'(total_blocks) - 1)));
                else if (pick < 83)
                    send_cmd(fbfl_pkg::OP_FREE, 10'($urandom));
                else if (pick < 97)
                    send_cmd(fbfl_pkg::OP_QUERY, 10'($urandom));
                else
                    send_cmd(fbfl_pkg::OP_INIT, 10'($urandom));
            end
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        head_ptr     = '0;
        total_blocks = '0;
        free_cnt     = '0;
        stride_bytes = '0;
        cfg_pool     = fbfl_pkg::POOL_BYTES_RST;
        cfg_req      = fbfl_pkg::REQ_BYTES_RST;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_before_init();
        test_default_pool();
        test_stride_and_size();
        test_double_free();
        test_random_traffic();

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/fbfl_pkg.sv
hdl/fbfl_div.sv
hdl/fbfl_ctrl.sv
hdl/fixed_block_free_list_allocator_unit.sv
hdl/fbfl_chk.sv
test/tb_top.sv
